>>> rtl/core/dtfb_pkg.sv
package dtfb_pkg;

   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 768;
   localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(PIXEL_COUNT);
   localparam int COORD_W       = 12;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] DEPTH_FAR   = 32'h7FFF_FFFF;
   localparam logic [7:0]  ALPHA_FULL  = 8'hFF;
   localparam logic [7:0]  CLEAR_RESET = 8'd30;

   localparam logic [1:0] CSR_RED   = 2'd0;
   localparam logic [1:0] CSR_GREEN = 2'd1;
   localparam logic [1:0] CSR_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OFF  = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_CLEAR = 2'd1,
      BK_LOOK  = 2'd2
   } back_state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic               on_screen;
      logic [ADDR_W-1:0]  addr;
      logic signed [31:0] depth;
      logic [31:0]        colour;
   } item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } clear_colour_type;

endpackage

>>> rtl/core/depth_tested_framebuffer_top.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  cmd, pos_x, pos_y, new_depth, in_* bytes
// rsp       out        rsp_valid / rsp_stall  status, pixel_word, stored_depth
// csr       in         csr_valid / csr_ready  csr_index, csr_data (always ready)
//
// draw and read go through the back end as pop and memory read, then test and write,
// and no new item is popped until the last is done; off-screen and unused commands are answered at pop.
// clear sweeps one entry per cycle through all 786432 entries of both stores.
// a 2-entry queue sits between front and back; req_stall is high only while it is full.
// reset (synchronous) empties the queue and the result register and restores clear colour 30.
// colour and depth stores hold garbage until the first clear.
module depth_tested_framebuffer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic signed [dtfb_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [dtfb_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [31:0]                  req_new_depth,
   input  logic [7:0]                          req_in_red,
   input  logic [7:0]                          req_in_green,
   input  logic [7:0]                          req_in_blue,
   input  logic [7:0]                          req_in_alpha,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [31:0]                         rsp_pixel_word,
   output logic signed [31:0]                  rsp_stored_depth,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [7:0]                          csr_data
);

   dtfb_pkg::clear_colour_type clear_ff, clear_in;
   dtfb_pkg::item_type push_item;
   dtfb_pkg::item_type pop_item;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      clear_in = clear_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dtfb_pkg::CSR_RED:   clear_in.red   = csr_data;
            dtfb_pkg::CSR_GREEN: clear_in.green = csr_data;
            dtfb_pkg::CSR_BLUE:  clear_in.blue  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '{red: dtfb_pkg::CLEAR_RESET, green: dtfb_pkg::CLEAR_RESET,
                       blue: dtfb_pkg::CLEAR_RESET};
      end else begin
         clear_ff <= clear_in;
      end
   end

   dtfb_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_new_depth (req_new_depth),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .req_in_alpha  (req_in_alpha),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   dtfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   dtfb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .clear_colour     (clear_ff),
      .q_empty          (q_empty),
      .q_item           (pop_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_stored_depth (rsp_stored_depth)
   );

endmodule

>>> rtl/core/dtfb_front.sv
module dtfb_front (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_cmd,
   input  logic signed [dtfb_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [dtfb_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [31:0]                    req_new_depth,
   input  logic [7:0]                            req_in_red,
   input  logic [7:0]                            req_in_green,
   input  logic [7:0]                            req_in_blue,
   input  logic [7:0]                            req_in_alpha,
   input  logic                                  q_full,
   output logic                                  q_push,
   output dtfb_pkg::item_type                    q_item
);

   logic on_x;
   logic on_y;
   logic [31:0] lin_addr;

   always_comb begin
      on_x = !req_pos_x[dtfb_pkg::COORD_W-1]
             && (int'(req_pos_x) < dtfb_pkg::SCREEN_WIDTH);
      on_y = !req_pos_y[dtfb_pkg::COORD_W-1]
             && (int'(req_pos_y) < dtfb_pkg::SCREEN_HEIGHT);
      // row times width plus column, only meaningful on screen
      lin_addr = 32'(req_pos_y[dtfb_pkg::COORD_W-2:0]) * 32'(dtfb_pkg::SCREEN_WIDTH)
                 + 32'(req_pos_x[dtfb_pkg::COORD_W-2:0]);

      q_item.cmd       = dtfb_pkg::cmd_type'(req_cmd);
      q_item.on_screen = on_x && on_y;
      q_item.addr      = lin_addr[dtfb_pkg::ADDR_W-1:0];
      q_item.depth     = req_new_depth;
      q_item.colour    = {req_in_red, req_in_green, req_in_blue, req_in_alpha};

      req_stall = q_full;
      q_push    = req_valid && !q_full;
   end

endmodule

>>> rtl/core/dtfb_queue.sv
module dtfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dtfb_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output dtfb_pkg::item_type pop_item,
   output logic               empty
);

   dtfb_pkg::item_type entry_ff [dtfb_pkg::QUEUE_DEPTH];
   logic [dtfb_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dtfb_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dtfb_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full     = (count_ff == dtfb_pkg::QUEUE_CNT_W'(dtfb_pkg::QUEUE_DEPTH));
      empty    = (count_ff == '0);
      pop_item = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dtfb_pkg::QUEUE_PTR_W'(dtfb_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dtfb_pkg::QUEUE_PTR_W'(dtfb_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/dtfb_back.sv
module dtfb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dtfb_pkg::clear_colour_type clear_colour,
   input  logic                       q_empty,
   input  dtfb_pkg::item_type         q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [31:0]                rsp_pixel_word,
   output logic signed [31:0]         rsp_stored_depth
);

   logic [31:0] colour_mem [dtfb_pkg::PIXEL_COUNT];
   logic [31:0] depth_mem  [dtfb_pkg::PIXEL_COUNT];

   dtfb_pkg::back_state_type state_ff, state_in;
   logic [dtfb_pkg::ADDR_W-1:0] clr_ff, clr_in;
   dtfb_pkg::item_type cur_ff, cur_in;

   logic                rsp_valid_ff, rsp_valid_in;
   dtfb_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]         rsp_word_ff, rsp_word_in;
   logic [31:0]         rsp_depth_ff, rsp_depth_in;

   logic [31:0] colour_rd_ff;
   logic [31:0] depth_rd_ff;

   logic                        mem_we;
   logic [dtfb_pkg::ADDR_W-1:0] mem_waddr;
   logic [31:0]                 mem_wcolour;
   logic [31:0]                 mem_wdepth;
   logic                        mem_re;
   logic [dtfb_pkg::ADDR_W-1:0] mem_raddr;
   logic                        slot_free;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_depth_in  = rsp_depth_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = clr_ff;
      mem_wcolour   = {clear_colour.red, clear_colour.green, clear_colour.blue,
                       dtfb_pkg::ALPHA_FULL};
      mem_wdepth    = dtfb_pkg::DEPTH_FAR;
      mem_re        = 1'b0;
      mem_raddr     = q_item.addr;
      // the result slot is free by the time any popped item finishes
      slot_free     = !rsp_valid_ff || !rsp_stall;

      unique case (state_ff)
         dtfb_pkg::BK_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               unique case (q_item.cmd)
                  dtfb_pkg::CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = dtfb_pkg::BK_CLEAR;
                  end
                  dtfb_pkg::CMD_DRAW, dtfb_pkg::CMD_READ: begin
                     if (q_item.on_screen) begin
                        mem_re   = 1'b1;
                        state_in = dtfb_pkg::BK_LOOK;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = dtfb_pkg::ST_OFF;
                        rsp_word_in   = '0;
                        rsp_depth_in  = '0;
                     end
                  end
                  dtfb_pkg::CMD_NONE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = dtfb_pkg::ST_OK;
                     rsp_word_in   = '0;
                     rsp_depth_in  = '0;
                  end
               endcase
            end
         end
         dtfb_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == dtfb_pkg::ADDR_W'(dtfb_pkg::PIXEL_COUNT - 1)) begin
               clr_in        = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = dtfb_pkg::ST_OK;
               rsp_word_in   = '0;
               rsp_depth_in  = '0;
               state_in      = dtfb_pkg::BK_IDLE;
            end
         end
         dtfb_pkg::BK_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = dtfb_pkg::BK_IDLE;
            mem_waddr    = cur_ff.addr;
            mem_wcolour  = cur_ff.colour;
            mem_wdepth   = cur_ff.depth;
            priority if (cur_ff.cmd == dtfb_pkg::CMD_DRAW) begin
               rsp_word_in  = '0;
               rsp_depth_in = '0;
               // strict signed less-than wins the pixel
               if (cur_ff.depth < $signed(depth_rd_ff)) begin
                  mem_we        = 1'b1;
                  rsp_status_in = dtfb_pkg::ST_OK;
               end else begin
                  rsp_status_in = dtfb_pkg::ST_FAIL;
               end
            end else begin
               rsp_status_in = dtfb_pkg::ST_OK;
               rsp_word_in   = colour_rd_ff;
               rsp_depth_in  = depth_rd_ff;
            end
         end
         default: begin
            state_in = dtfb_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtfb_pkg::BK_IDLE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         colour_mem[mem_waddr] <= mem_wcolour;
         depth_mem[mem_waddr]  <= mem_wdepth;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         colour_rd_ff <= colour_mem[mem_raddr];
         depth_rd_ff  <= depth_mem[mem_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pixel_word   = rsp_word_ff;
   assign rsp_stored_depth = rsp_depth_ff;

endmodule
